>>> rtl/core/iconv_pkg.sv
`default_nettype none

package iconv_pkg;

   // fixed field widths
   localparam int SAMPLE_W     = 8;
   localparam int ROW_OUT_W    = 12;
   localparam int COL_OUT_W    = 11;
   localparam int CHAN_OUT_W   = 2;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_CHANS_W  = 3;
   localparam int CFG_KERNEL_W = 3;

   // CSR port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_IMAGE_WIDTH   = 2'd0;
   localparam csr_idx_type CSR_CHANNEL_COUNT = 2'd1;
   localparam csr_idx_type CSR_KERNEL_SELECT = 2'd2;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_IMAGE_WIDTH   = 12'd640;
   localparam logic [CFG_CHANS_W-1:0]  RESET_CHANNEL_COUNT = 3'd1;
   localparam logic [CFG_KERNEL_W-1:0] RESET_KERNEL_SELECT = 3'd0;

   typedef logic [CFG_KERNEL_W-1:0] kernel_type;

   localparam kernel_type KERN_IDENTITY   = 3'd0;
   localparam kernel_type KERN_BLUR       = 3'd1;
   localparam kernel_type KERN_SHARPEN    = 3'd2;
   localparam kernel_type KERN_OUTLINE    = 3'd3;
   localparam kernel_type KERN_SOBEL_LEFT = 3'd4;
   localparam kernel_type KERN_SOBEL_TOP  = 3'd5;

   typedef logic [SAMPLE_W-1:0] pix_type;

endpackage

`default_nettype wire

>>> rtl/core/iconv_req_if.sv
`default_nettype none

interface iconv_req_if;
   import iconv_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

`default_nettype wire

>>> rtl/core/iconv_rsp_if.sv
`default_nettype none

interface iconv_rsp_if;
   import iconv_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SAMPLE_W-1:0]   filtered_sample;
   logic [ROW_OUT_W-1:0]  center_row;
   logic [COL_OUT_W-1:0]  center_col;
   logic [CHAN_OUT_W-1:0] channel_index;

   modport source (
      output valid, output filtered_sample, output center_row,
      output center_col, output channel_index, input ready
   );
   modport sink (
      input valid, input filtered_sample, input center_row,
      input center_col, input channel_index, output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/image_conv3x3_filter.sv
// Result path: an accepted input beat passes the s1 register, the window register
// and the output register before its result is presented; a stalled rsp_ready holds it.
// Throughput: one input beat per cycle unless rsp_ready stalls; set by the single line-buffer
// RAM (one read and one write per cycle) and the per-channel tap update.
// Reset: synchronous, clears positions, pipeline valids and CSRs (to 640/1/0).
// Line buffers are not cleared; no clearing pass, the block is ready at once.
`default_nettype none

module image_conv3x3_filter #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_HEIGHT   = 4096
) (
   input  wire                               clock,
   input  wire                               reset,
   iconv_req_if.sink                         req_bus,
   iconv_rsp_if.source                       rsp_bus,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [iconv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [iconv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [iconv_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import iconv_pkg::*;

   // ---------------------------------------------------------------------
   // derived sizes
   // ---------------------------------------------------------------------
   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int AW  = $clog2(LINE_DEPTH);          // line buffer address
   localparam int CLW = $clog2(MAX_WIDTH);           // column position
   localparam int RW  = $clog2(MAX_HEIGHT);          // row position
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = ((WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W) + 1;  // width compares
   localparam int RXW = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
   localparam int CXW = (CLW > COL_OUT_W) ? CLW : COL_OUT_W;

   // ---------------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------------
   logic [CFG_WIDTH_W-1:0] width_ff;
   logic [CFG_CHANS_W-1:0] chans_ff;
   kernel_type             kern_ff;
   logic                   csr_wr;
   csr_idx_type            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_IMAGE_WIDTH;
         chans_ff <= RESET_CHANNEL_COUNT;
         kern_ff  <= RESET_KERNEL_SELECT;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_IMAGE_WIDTH:   width_ff <= csr_pwdata[CFG_WIDTH_W-1:0];
            CSR_CHANNEL_COUNT: chans_ff <= csr_pwdata[CFG_CHANS_W-1:0];
            CSR_KERNEL_SELECT: kern_ff  <= csr_pwdata[CFG_KERNEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IMAGE_WIDTH:   csr_prdata = CSR_DATA_W'(width_ff);
         CSR_CHANNEL_COUNT: csr_prdata = CSR_DATA_W'(chans_ff);
         CSR_KERNEL_SELECT: csr_prdata = CSR_DATA_W'(kern_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // effective limits: width clamps to [1, MAX_WIDTH], channels to [1, MAX_CHANNELS]
   logic [CW-1:0]          width_x;
   logic [CW-1:0]          width_eff;
   logic [CFG_CHANS_W-1:0] chans_eff;

   assign width_x = CW'(width_ff);

   always_comb begin
      if (width_x > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else if (width_x == '0) begin
         width_eff = CW'(1);
      end else begin
         width_eff = width_x;
      end
      if (chans_ff > CFG_CHANS_W'(MAX_CHANNELS)) begin
         chans_eff = CFG_CHANS_W'(MAX_CHANNELS);
      end else if (chans_ff == '0) begin
         chans_eff = CFG_CHANS_W'(1);
      end else begin
         chans_eff = chans_ff;
      end
   end

   // ---------------------------------------------------------------------
   // pipeline handshakes
   //   s0: accept beat, advance position, issue line buffer read
   //   s1: RAM data back, assemble window, write back RAM and taps
   //   s2: window registered, kernel math
   //   s3: output register
   // each stage moves when it is empty or its successor takes it
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_emit_ff;
   logic s3_ready, s2_ready, s1_fire, accept;

   assign s3_ready = !rsp_valid_ff || rsp_bus.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_fire  = s1_valid_ff && (!s1_emit_ff || s2_ready);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign accept   = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------------
   // s0: raster position
   // ---------------------------------------------------------------------
   logic [CLW-1:0] col_ff, col_cur, col_in;
   logic [RW-1:0]  row_ff, row_cur, row_in;
   logic [CHW-1:0] chan_ff, chan_cur, chan_in;
   logic [AW-1:0]  idx_cur;
   logic           emit_cur;
   logic [RXW-1:0] row_out_x;
   logic [CXW-1:0] col_out_x;

   // frame start restarts the raster at this beat
   assign col_cur  = req_bus.frame_start ? '0 : col_ff;
   assign row_cur  = req_bus.frame_start ? '0 : row_ff;
   assign chan_cur = req_bus.frame_start ? '0 : chan_ff;

   assign idx_cur  = AW'(AW'(col_cur) * AW'(MAX_CHANNELS)) + AW'(chan_cur);
   // window below-right complete: centre is interior
   assign emit_cur = (row_cur >= RW'(2)) && (col_cur >= CLW'(2));
   assign row_out_x = RXW'(row_cur) - RXW'(1);
   assign col_out_x = CXW'(col_cur) - CXW'(1);

   // positions at or past a new limit wrap on the next advance
   always_comb begin
      col_in  = col_cur;
      row_in  = row_cur;
      chan_in = chan_cur;
      if (CFG_CHANS_W'(chan_cur) + CFG_CHANS_W'(1) >= chans_eff) begin
         chan_in = '0;
         if (CW'(col_cur) + CW'(1) >= width_eff) begin
            col_in = '0;
            // row count saturates; rows keep flowing through the buffers
            if (row_cur < RW'(MAX_HEIGHT - 1)) begin
               row_in = row_cur + RW'(1);
            end
         end else begin
            col_in = col_cur + CLW'(1);
         end
      end else begin
         chan_in = chan_cur + CHW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         chan_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         chan_ff <= chan_in;
      end
   end

   // ---------------------------------------------------------------------
   // line buffers: one RAM, word = {two rows above, row above}
   // ---------------------------------------------------------------------
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [2*SAMPLE_W-1:0] ram_wr_data;
   logic [2*SAMPLE_W-1:0] ram_rd_data;

   iconv_ram #(
      .WIDTH (2*SAMPLE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (idx_cur),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // s1 registers
   // ---------------------------------------------------------------------
   logic [AW-1:0]         s1_idx_ff;
   logic [CHW-1:0]        s1_chan_ff;
   pix_type               s1_sample_ff;
   logic [ROW_OUT_W-1:0]  s1_row_ff;
   logic [COL_OUT_W-1:0]  s1_col_ff;
   logic                  s1_fwd_hit_ff;
   logic [2*SAMPLE_W-1:0] s1_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff      <= idx_cur;
         s1_chan_ff     <= chan_cur;
         s1_sample_ff   <= req_bus.sample;
         s1_emit_ff     <= emit_cur;
         s1_row_ff      <= row_out_x[ROW_OUT_W-1:0];
         s1_col_ff      <= col_out_x[COL_OUT_W-1:0];
         // write-back of the beat ahead lands on the same entry this cycle
         s1_fwd_hit_ff  <= ram_wr_en && (ram_wr_addr == idx_cur);
         s1_fwd_data_ff <= ram_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // s1: window assembly and write-back
   // taps per channel: [0..2] column c-2 top/mid/bot, [3..5] column c-1
   // ---------------------------------------------------------------------
   pix_type               taps_ff [MAX_CHANNELS][6];
   logic [2*SAMPLE_W-1:0] mem_word;
   pix_type               top_px, mid_px, bot_px;
   pix_type               win [3][3];

   assign mem_word = s1_fwd_hit_ff ? s1_fwd_data_ff : ram_rd_data;
   assign top_px   = mem_word[2*SAMPLE_W-1:SAMPLE_W];
   assign mid_px   = mem_word[SAMPLE_W-1:0];
   assign bot_px   = s1_sample_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[r][0] = taps_ff[s1_chan_ff][r];
         win[r][1] = taps_ff[s1_chan_ff][3+r];
      end
      win[0][2] = top_px;
      win[1][2] = mid_px;
      win[2][2] = bot_px;
   end

   assign ram_wr_en   = s1_fire;
   assign ram_wr_addr = s1_idx_ff;
   assign ram_wr_data = {mid_px, bot_px};

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            taps_ff[s1_chan_ff][r] <= taps_ff[s1_chan_ff][3+r];
         end
         taps_ff[s1_chan_ff][3] <= top_px;
         taps_ff[s1_chan_ff][4] <= mid_px;
         taps_ff[s1_chan_ff][5] <= bot_px;
      end
   end

   // ---------------------------------------------------------------------
   // s2: registered window, kernel
   // ---------------------------------------------------------------------
   pix_type               s2_win_ff [3][3];
   logic [ROW_OUT_W-1:0]  s2_row_ff;
   logic [COL_OUT_W-1:0]  s2_col_ff;
   logic [CHAN_OUT_W-1:0] s2_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_fire && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_fire && s1_emit_ff) begin
         s2_win_ff  <= win;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_chan_ff <= CHAN_OUT_W'(s1_chan_ff);
      end
   end

   // integer kernels only need the low byte: 8-bit math wraps the same way
   logic [11:0] blur_sum;
   pix_type     k_out;

   always_comb begin
      blur_sum = 12'(s2_win_ff[0][0]) + {3'b0, s2_win_ff[0][1], 1'b0}
               + 12'(s2_win_ff[0][2]) + {3'b0, s2_win_ff[1][0], 1'b0}
               + {2'b0, s2_win_ff[1][1], 2'b0} + {3'b0, s2_win_ff[1][2], 1'b0}
               + 12'(s2_win_ff[2][0]) + {3'b0, s2_win_ff[2][1], 1'b0}
               + 12'(s2_win_ff[2][2]);
      case (kern_ff)
         KERN_BLUR: begin
            k_out = blur_sum[11:4];
         end
         KERN_SHARPEN: begin
            k_out = {s2_win_ff[1][1][5:0], 2'b00} + s2_win_ff[1][1]
                  - s2_win_ff[0][1] - s2_win_ff[1][0]
                  - s2_win_ff[1][2] - s2_win_ff[2][1];
         end
         KERN_OUTLINE: begin
            k_out = {s2_win_ff[1][1][4:0], 3'b000}
                  - s2_win_ff[0][0] - s2_win_ff[0][1] - s2_win_ff[0][2]
                  - s2_win_ff[1][0] - s2_win_ff[1][2]
                  - s2_win_ff[2][0] - s2_win_ff[2][1] - s2_win_ff[2][2];
         end
         KERN_SOBEL_LEFT: begin
            k_out = s2_win_ff[0][0] - s2_win_ff[0][2]
                  + {s2_win_ff[1][0][6:0], 1'b0} - {s2_win_ff[1][2][6:0], 1'b0}
                  + s2_win_ff[2][0] - s2_win_ff[2][2];
         end
         KERN_SOBEL_TOP: begin
            k_out = s2_win_ff[0][0] + {s2_win_ff[0][1][6:0], 1'b0} + s2_win_ff[0][2]
                  - s2_win_ff[2][0] - {s2_win_ff[2][1][6:0], 1'b0} - s2_win_ff[2][2];
         end
         default: begin
            // identity, and the unused codes
            k_out = s2_win_ff[1][1];
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // s3: output register
   // ---------------------------------------------------------------------
   pix_type               rsp_sample_ff;
   logic [ROW_OUT_W-1:0]  rsp_row_ff;
   logic [COL_OUT_W-1:0]  rsp_col_ff;
   logic [CHAN_OUT_W-1:0] rsp_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         rsp_sample_ff <= k_out;
         rsp_row_ff    <= s2_row_ff;
         rsp_col_ff    <= s2_col_ff;
         rsp_chan_ff   <= s2_chan_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.filtered_sample = rsp_sample_ff;
   assign rsp_bus.center_row      = rsp_row_ff;
   assign rsp_bus.center_col      = rsp_col_ff;
   assign rsp_bus.channel_index   = rsp_chan_ff;

endmodule

`default_nettype wire

>>> rtl/core/iconv_ram.sv
`default_nettype none

// simple dual-port RAM, registered read, read-first on address collision
module iconv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                  wr_data,
   input  wire                              rd_en,
   input  wire [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

>>> dv/image_conv3x3_filter_checker.sv
module image_conv3x3_filter_checker #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_HEIGHT   = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   iconv_req_if                             req_mon,
   iconv_rsp_if                             rsp_mon,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire                              csr_pready,
   input  wire [iconv_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire [iconv_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output int                               fail_count,
   output int                               pending,
   output int                               result_count,
   output int                               beat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import iconv_pkg::*;

   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;

   typedef struct packed {
      pix_type               value;
      logic [ROW_OUT_W-1:0]  row;
      logic [COL_OUT_W-1:0]  col;
      logic [CHAN_OUT_W-1:0] chan;
   } filtered_px_type;

   logic [CFG_WIDTH_W-1:0] width_reg;
   logic [CFG_CHANS_W-1:0] chans_reg;
   kernel_type             kernel_reg;

   pix_type     row_above     [LINE_DEPTH];
   pix_type     row_two_above [LINE_DEPTH];
   pix_type     win_taps      [MAX_CHANNELS*6];
   int unsigned col_pos, row_pos, chan_pos;

   filtered_px_type expected_px [$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
      beat_count   = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // one accepted sample: window update, optional filtered pixel, position advance
   task automatic filter_beat(input pix_type value, input logic first);
      int unsigned     w, nch, ch, col, idx, t;
      int              p [3][3];
      int              acc;
      pix_type         top_px, mid_px;
      filtered_px_type px;
      w = width_reg;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      else if (w == 0) w = 1;
      nch = chans_reg;
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      else if (nch == 0) nch = 1;
      if (first) begin
         col_pos  = 0;
         row_pos  = 0;
         chan_pos = 0;
      end
      ch     = chan_pos % MAX_CHANNELS;
      col    = col_pos % MAX_WIDTH;
      idx    = (col * MAX_CHANNELS + ch) % LINE_DEPTH;
      t      = ch * 6;
      top_px = row_two_above[idx];
      mid_px = row_above[idx];
      for (int r = 0; r < 3; r++) begin
         p[r][0] = win_taps[t + r];
         p[r][1] = win_taps[t + 3 + r];
      end
      p[0][2] = top_px;
      p[1][2] = mid_px;
      p[2][2] = value;

      if (row_pos >= 2 && col >= 2) begin
         case (kernel_reg)
            KERN_BLUR: begin
               acc = (p[0][0] + 2*p[0][1] + p[0][2]
                      + 2*p[1][0] + 4*p[1][1] + 2*p[1][2]
                      + p[2][0] + 2*p[2][1] + p[2][2]) / 16;
            end
            KERN_SHARPEN: begin
               acc = 5*p[1][1] - p[0][1] - p[1][0] - p[1][2] - p[2][1];
            end
            KERN_OUTLINE: begin
               acc = 8*p[1][1] - p[0][0] - p[0][1] - p[0][2] - p[1][0]
                     - p[1][2] - p[2][0] - p[2][1] - p[2][2];
            end
            KERN_SOBEL_LEFT: begin
               acc = p[0][0] - p[0][2] + 2*p[1][0] - 2*p[1][2] + p[2][0] - p[2][2];
            end
            KERN_SOBEL_TOP: begin
               acc = p[0][0] + 2*p[0][1] + p[0][2] - p[2][0] - 2*p[2][1] - p[2][2];
            end
            default: begin
               acc = p[1][1];
            end
         endcase
         px.value = acc[7:0];
         px.row   = ROW_OUT_W'(row_pos - 1);
         px.col   = COL_OUT_W'(col - 1);
         px.chan  = CHAN_OUT_W'(ch);
         expected_px.push_back(px);
      end

      for (int r = 0; r < 3; r++) win_taps[t + r] = win_taps[t + 3 + r];
      win_taps[t + 3]    = top_px;
      win_taps[t + 4]    = mid_px;
      win_taps[t + 5]    = value;
      row_two_above[idx] = mid_px;
      row_above[idx]     = value;

      if (chan_pos + 1 >= nch) begin
         chan_pos = 0;
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos < MAX_HEIGHT - 1) row_pos++;
         end else begin
            col_pos++;
         end
      end else begin
         chan_pos++;
      end
   endtask

   task automatic check_result();
      filtered_px_type want;
      if (expected_px.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing expected (row %0d col %0d ch %0d)",
                                   rsp_mon.center_row, rsp_mon.center_col,
                                   rsp_mon.channel_index));
         return;
      end
      want = expected_px.pop_front();
      result_count++;
      if (rsp_mon.filtered_sample !== want.value)
         report_mismatch($sformatf("filtered_sample %0d, expected %0d at row %0d col %0d ch %0d",
                                   rsp_mon.filtered_sample, want.value, want.row,
                                   want.col, want.chan));
      if (rsp_mon.center_row !== want.row)
         report_mismatch($sformatf("center_row %0d, expected %0d", rsp_mon.center_row, want.row));
      if (rsp_mon.center_col !== want.col)
         report_mismatch($sformatf("center_col %0d, expected %0d", rsp_mon.center_col, want.col));
      if (rsp_mon.channel_index !== want.chan)
         report_mismatch($sformatf("channel_index %0d, expected %0d", rsp_mon.channel_index,
                                   want.chan));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = RESET_IMAGE_WIDTH;
         chans_reg  = RESET_CHANNEL_COUNT;
         kernel_reg = RESET_KERNEL_SELECT;
         col_pos    = 0;
         row_pos    = 0;
         chan_pos   = 0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         for (int i = 0; i < MAX_CHANNELS*6; i++) win_taps[i] = '0;
      end else begin
         // input beat first so a same-edge result still pops the oldest entry
         if (req_mon.valid && req_mon.ready) begin
            filter_beat(req_mon.sample, req_mon.frame_start);
            beat_count++;
         end
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_idx_type'(csr_paddr[3:2]))
               CSR_IMAGE_WIDTH:   width_reg  = csr_pwdata[CFG_WIDTH_W-1:0];
               CSR_CHANNEL_COUNT: chans_reg  = csr_pwdata[CFG_CHANS_W-1:0];
               CSR_KERNEL_SELECT: kernel_reg = csr_pwdata[CFG_KERNEL_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_px.size();
   end

endmodule

>>> dv/image_conv3x3_filter_tb.sv
module image_conv3x3_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iconv_pkg::*;

   localparam int MAX_CHANNELS = 4;

   // the limit leaves wide margin over the slowest correct run (~1.4k beats, worst gaps and stalls)
   localparam int CYCLE_LIMIT  = 200_000;
   // let the block's pipeline registers drain before touching the registers
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BEATS = 1150;

   // select codes 6 and 7 fall back to identity
   localparam kernel_type KERN_UNKNOWN = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   iconv_req_if req_bus ();
   iconv_rsp_if rsp_bus ();

   // from the checker
   int fail_count;
   int pending;
   int result_count;
   int beat_count;

   int             cycle_count  = 0;
   int             beats_sent   = 0;
   int             burst_left   = 0;
   int             csr_writes   = 0;
   int             frames_sent  = 0;
   stall_mode_type stall_mode   = STALL_NONE;
   int             stall_span   = 0;
   int             stall_phase  = 0;

   kernel_type directed_kernels [7] = '{KERN_IDENTITY, KERN_BLUR, KERN_SHARPEN, KERN_OUTLINE,
                                        KERN_SOBEL_LEFT, KERN_SOBEL_TOP, KERN_UNKNOWN};

   always #5 clock = ~clock;

   image_conv3x3_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   image_conv3x3_filter_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count),
      .beat_count   (beat_count)
   );

   // watchdog: a hang or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d, %0d results still outstanding", cycle_count, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side backpressure: the pattern is redrawn whenever its random span runs out,
   // including stretches that are always ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 96);
         end
         stall_span--;
         stall_phase++;
         case (stall_mode)
            STALL_NONE:     rsp_bus.ready <= 1'b1;
            STALL_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: rsp_bus.ready <= ((stall_phase % 8) >= 3);
            default:        rsp_bus.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   function automatic pix_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // APB write: setup cycle, then access cycle; pready is always high but is honored
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // idle after the access so back-to-back writes never reassign psel in the same step
      @(posedge clock);
      csr_writes++;
   endtask

   // drop valid and hold off until every expected result has come, then let
   // any result-free beat still in the pipe drain out
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input int w, input int nch, input kernel_type k);
      settle();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_CHANNEL_COUNT, nch);
      write_csr(CSR_KERNEL_SELECT, CSR_DATA_W'(k));
   endtask

   // one beat; the sender runs in bursts with random gaps between them
   task automatic send_beat(input pix_type value, input logic first);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= value;
      req_bus.frame_start <= first;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // rows of line_px pixels with px_chans samples each; stop_at > 0 cuts the frame short,
   // noisy scatters stray frame starts, opening marks the first beat as a frame start
   task automatic send_frame(input int line_px, input int px_chans, input int rows,
                             input int stop_at, input bit noisy, input bit opening);
      int   total;
      logic mark;
      total = rows * line_px * px_chans;
      if (stop_at > 0 && stop_at < total) total = stop_at;
      for (int i = 0; i < total; i++) begin
         mark = (opening && i == 0) || (noisy && $urandom_range(0, 199) == 0);
         send_beat(pick_sample(), mark);
      end
      frames_sent++;
   endtask

   initial begin
      int w, nch, eff_w, eff_n, rows, stop, random_start;
      kernel_type k;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.sample      <= '0;
      req_bus.frame_start <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: 3-wide frame, kernel switched between rows ----
      // rows 0 and 1 only fill the line buffers; from row 2 on every row yields
      // exactly one pixel (column 1), so each kernel code gets one hard-valued window
      set_regs(3, 1, KERN_IDENTITY);
      for (int r = 0; r < 2 + 7; r++) begin
         if (r >= 2) begin
            settle();
            write_csr(CSR_KERNEL_SELECT, CSR_DATA_W'(directed_kernels[r - 2]));
         end
         for (int c = 0; c < 3; c++)
            send_beat(((r * 5 + c * 3) % 7 < 3) ? 8'hFF : 8'h00, (r == 0 && c == 0));
      end
      frames_sent++;

      // ---- mid-frame shrink ----
      // stop at column 7, channel 1 of row 4, then cut width and channel count;
      // the position wraps on the next advance
      set_regs(10, 2, KERN_SOBEL_LEFT);
      send_frame(10, 2, 5, 4 * 20 + 15, 1'b0, 1'b1);
      set_regs(4, 1, KERN_SOBEL_TOP);
      send_frame(4, 1, 3, 1, 1'b0, 1'b0);
      send_frame(4, 1, 3, 0, 1'b0, 1'b0);

      // ---- random: new register setting per phase, whole frames mostly ----
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(17, 40);
            default: w = $urandom_range(3, 16);
         endcase
         nch = $urandom_range(0, 7);
         k   = kernel_type'($urandom_range(0, 7));
         set_regs(w, nch, k);
         eff_w = (w == 0) ? 1 : w;
         eff_n = (nch == 0) ? 1 : ((nch > MAX_CHANNELS) ? MAX_CHANNELS : nch);
         repeat ($urandom_range(1, 2)) begin
            rows = (eff_w < 3) ? $urandom_range(2, 5) : $urandom_range(3, 6);
            stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rows * eff_w * eff_n) : 0;
            send_frame(eff_w, eff_n, rows, stop, ($urandom_range(0, 3) == 0), 1'b1);
         end
      end

      settle();

      $display("Run summary: %0d input beats, %0d frames, %0d pixels checked, %0d reg writes",
               beat_count, frames_sent, result_count, csr_writes);
      $display("Exercised every kernel code, mid-frame shrink, odd widths and channel counts");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
